// ----- design/triangle_quality_metrics_assert.svh -----
// Assertion macros for the triangle quality block
`ifndef TRIANGLE_QUALITY_METRICS_ASSERT_SVH
`define TRIANGLE_QUALITY_METRICS_ASSERT_SVH
`ifndef SYNTHESIS
`define TQM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tqm assertion failed");
`define TQM_ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) !rst_n |=> prop) \
    else $error("tqm reset assertion failed");
`else
`define TQM_ASSERT(lbl, clk, rst_n, prop)
`define TQM_ASSERT_RST(lbl, clk, rst_n, prop)
`endif
`endif

// ----- design/tqm_pkg.sv -----
// Types and constants shared by the triangle quality block
`timescale 1ns / 1ps
package tqm_pkg;

  localparam int unsigned MUL_LAT = 3;

  localparam logic [31:0] QUAL_CAP    = 32'd4096000000;
  localparam logic [31:0] STRETCH_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [31:0]        rest_len_a;
    logic [31:0]        rest_len_b;
    logic [31:0]        rest_len_c;
  } tqm_in_t;

  typedef struct packed {
    logic [31:0] quality;
    logic        degenerate;
    logic [31:0] stretch;
  } tqm_out_t;

endpackage

// ----- design/tqm_mul.sv -----
// Pipelined unsigned multiplier built from 32x32 partial products
`timescale 1ns / 1ps
module tqm_mul #(
  parameter int unsigned WA = 32,
  parameter int unsigned WB = 32
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [WA-1:0]   a_i,
  input  logic [WB-1:0]   b_i,
  output logic [WA+WB-1:0] p_o
);

  localparam int unsigned NA  = (WA + 31) / 32;
  localparam int unsigned NB  = (WB + 31) / 32;
  localparam int unsigned WAE = 32 * NA;
  localparam int unsigned WBE = 32 * NB;
  localparam int unsigned WR  = 32 * (NB + 1);
  localparam int unsigned WP  = 32 * (NA + NB);

  logic [WAE-1:0]     a_ext;
  logic [WBE-1:0]     b_ext;
  logic [63:0]        pp_q [NA][NB];
  logic [WR-1:0]      row_d [NA];
  logic [WR-1:0]      row_q [NA];
  logic [WP-1:0]      sum_d;
  logic [WA+WB-1:0]   p_q;

  assign a_ext = WAE'(a_i);
  assign b_ext = WBE'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= 64'(a_ext[32*i +: 32]) * 64'(b_ext[32*j +: 32]);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_d[i] = row_d[i] + (WR'(pp_q[i][j]) << (32 * j));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row_q <= row_d;
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NA; i++) begin
      sum_d = sum_d + (WP'(row_q[i]) << (32 * i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= sum_d[WA+WB-1:0];
    end
  end

  assign p_o = p_q;

endmodule

// ----- design/tqm_delay.sv -----
// Enabled shift line that aligns a word with the rest of the pipeline
`timescale 1ns / 1ps
module tqm_delay #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int k = 1; k < N; k++) begin
        sr_q[k] <= sr_q[k-1];
      end
    end
  end

  assign q_o = sr_q[N-1];

endmodule

// ----- design/tqm_div.sv -----
// Pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module tqm_div #(
  parameter int unsigned WN = 8,
  parameter int unsigned WD = 8,
  parameter int unsigned WQ = 8
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [WN-1:0] num_i,
  input  logic [WD-1:0] den_i,
  output logic [WQ-1:0] quo_o
);

  localparam int unsigned WR = WD + WQ;

  logic [WR-1:0] rem_q [WQ];
  logic [WD-1:0] den_q [WQ];
  logic [WQ-1:0] quo_q [WQ];

  for (genvar k = 0; k < WQ; k++) begin : g_step
    localparam int unsigned B = WQ - 1 - k;
    logic [WR-1:0] rem_in;
    logic [WR-1:0] trial;
    logic [WR-1:0] rem_d;
    logic [WD-1:0] den_in;
    logic [WQ-1:0] quo_in;
    logic [WQ-1:0] quo_d;

    if (k == 0) begin : g_first
      assign rem_in = WR'(num_i);
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = WR'(den_in) << B;

    always_comb begin
      if (rem_in >= trial) begin
        rem_d = rem_in - trial;
        quo_d = quo_in | (WQ'(1) << B);
      end else begin
        rem_d = rem_in;
        quo_d = quo_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        den_q[k] <= den_in;
        quo_q[k] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[WQ-1];

endmodule

// ----- design/tqm_sqrt.sv -----
// Pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
module tqm_sqrt #(
  parameter int unsigned WX = 8
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [WX-1:0]   rad_i,
  output logic [WX/2-1:0] root_o
);

  localparam int unsigned WR = WX / 2;

  logic [WX:0]   rem_q  [WR];
  logic [WR-1:0] root_q [WR];

  for (genvar k = 0; k < WR; k++) begin : g_step
    localparam int unsigned B = WR - 1 - k;
    logic [WX:0]   rem_in;
    logic [WX:0]   trial;
    logic [WX:0]   rem_d;
    logic [WR-1:0] root_in;
    logic [WR-1:0] root_d;

    if (k == 0) begin : g_first
      assign rem_in  = (WX+1)'(rad_i);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign trial = ((WX+1)'(root_in) << (B + 1)) | ((WX+1)'(1) << (2 * B));

    always_comb begin
      if (rem_in >= trial) begin
        rem_d  = rem_in - trial;
        root_d = root_in | (WR'(1) << B);
      end else begin
        rem_d  = rem_in;
        root_d = root_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
      end
    end
  end

  assign root_o = root_q[WR-1];

endmodule

// ----- design/triangle_quality_metrics.sv -----
// Triangle quality top level: radius ratio, degenerate flag and stretch per triangle
// One triangle word enters per cycle while the output is not stalled, and the
// depth is set by the stretch path (a 128-step divider followed by 64- and 32-step
// square roots), the quality path being padded to match. Every stage advances
// together, so a stalled output freezes the whole pipeline and in_ready_o drops
// only while a finished word waits. area_floor is written through the cfg port
// at any time with no wait states and should change only while the block is empty.
`timescale 1ns / 1ps
`include "triangle_quality_metrics_assert.svh"
module triangle_quality_metrics (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tqm_pkg::tqm_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tqm_pkg::tqm_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [31:0]       cfg_data_i
);

  localparam int unsigned LM    = tqm_pkg::MUL_LAT;
  localparam int unsigned T_IN  = 1;
  localparam int unsigned T_M1  = T_IN + LM;
  localparam int unsigned T_C   = T_M1 + 1;
  localparam int unsigned T_M2  = T_C + LM;
  localparam int unsigned T_S   = T_M2 + 1;
  localparam int unsigned T_F   = T_S + 1;
  localparam int unsigned T_E   = T_C + 49;
  localparam int unsigned T_LL  = T_E + LM;
  localparam int unsigned T_L3  = T_LL + LM;
  localparam int unsigned T_N   = T_L3 + LM;
  localparam int unsigned T_QD  = T_N + 33;
  localparam int unsigned T_QR  = T_QD + 1;
  localparam int unsigned T_X   = T_S + 128;
  localparam int unsigned T_R1  = T_X + 64;
  localparam int unsigned T_R2  = T_R1 + 32;
  localparam int unsigned T_OUT = T_R2 + 1;

  function automatic logic [32:0] mag33(logic signed [32:0] x);
    return x[32] ? 33'(-x) : 33'(x);
  endfunction

  logic               en;
  logic [T_OUT-1:0]   vld_q;
  logic [T_OUT-1:0]   vld_d;
  logic [31:0]        area_floor_q;
  logic [65:0]        f2;

  logic signed [31:0] pa [3];
  logic signed [31:0] pb [3];
  logic signed [31:0] pc [3];
  logic signed [32:0] u_d [3];
  logic signed [32:0] v_d [3];
  logic signed [32:0] w_d [3];
  logic signed [32:0] u_q [3];
  logic signed [32:0] v_q [3];
  logic signed [32:0] w_q [3];
  logic signed [32:0] evec [3][3];
  logic [33:0]        rs_q;
  logic [32:0]        ta_q;
  logic [32:0]        tb_q;
  logic [32:0]        tc_q;
  logic               rok_q;
  logic               rok_d;
  logic [32:0]        sab;
  logic [32:0]        sac;
  logic [32:0]        sbc;

  logic [65:0]        xa_m [3];
  logic [65:0]        xb_m [3];
  logic [65:0]        esq_m [3][3];
  logic [5:0]         sgn_d;
  logic [5:0]         sgn_m;
  logic [66:0]        p1_m;
  logic [65:0]        p2_m;

  logic signed [67:0] ca_s [3];
  logic signed [67:0] cb_s [3];
  logic signed [67:0] cr_s [3];
  logic [66:0]        cm_d [3];
  logic [66:0]        cm_q [3];
  logic [65:0]        es_q [3];
  logic [66:0]        p1_q;
  logic [65:0]        p2_q;

  logic [133:0]       csq_m [3];
  logic [132:0]       pp_m;
  logic [135:0]       crsq_q;
  logic [132:0]       pp_q;
  logic               deg_q;
  logic               sat_q;

  logic [48:0]        lroot [3];
  logic [50:0]        lsum;
  logic [50:0]        lsum_l;
  logic [48:0]        lc_l;
  logic [97:0]        lalb_m;
  logic [146:0]       l3_m;
  logic [197:0]       num_m;
  logic [135:0]       crsq_n;
  logic               ovf_q;
  logic               ovf_l;
  logic               degq_l;
  logic [32:0]        quo;
  logic [31:0]        qual_q;
  logic [31:0]        qual_l;

  logic [127:0]       xq;
  logic [63:0]        r1;
  logic [31:0]        r2;
  logic               deg_l;
  logic               sat_l;
  logic               rok_l;
  tqm_pkg::tqm_out_t  out_q;

  assign en          = !vld_q[T_OUT-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[T_OUT-1];
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  assign vld_d = {vld_q[T_OUT-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_floor_q <= '0;
    end else if (cfg_valid_i) begin
      area_floor_q <= cfg_data_i;
    end
  end

  tqm_mul #(.WA(33), .WB(33)) u_floor_sq (
    .clk_i (clk_i),
    .en_i  (1'b1),
    .a_i   ({area_floor_q, 1'b0}),
    .b_i   ({area_floor_q, 1'b0}),
    .p_o   (f2)
  );

  // Input stage: edge vectors and rest-length terms
  always_comb begin
    pa[0] = in_data_i.ax;
    pa[1] = in_data_i.ay;
    pa[2] = in_data_i.az;
    pb[0] = in_data_i.bx;
    pb[1] = in_data_i.by;
    pb[2] = in_data_i.bz;
    pc[0] = in_data_i.cx;
    pc[1] = in_data_i.cy;
    pc[2] = in_data_i.cz;
    for (int k = 0; k < 3; k++) begin
      u_d[k] = 33'(pb[k]) - 33'(pa[k]);
      v_d[k] = 33'(pc[k]) - 33'(pa[k]);
      w_d[k] = 33'(pc[k]) - 33'(pb[k]);
    end
  end

  assign sbc   = 33'(in_data_i.rest_len_b) + 33'(in_data_i.rest_len_c);
  assign sac   = 33'(in_data_i.rest_len_a) + 33'(in_data_i.rest_len_c);
  assign sab   = 33'(in_data_i.rest_len_a) + 33'(in_data_i.rest_len_b);
  assign rok_d = (in_data_i.rest_len_a != '0) && (in_data_i.rest_len_b != '0) &&
                 (in_data_i.rest_len_c != '0) &&
                 (sbc > 33'(in_data_i.rest_len_a)) &&
                 (sac > 33'(in_data_i.rest_len_b)) &&
                 (sab > 33'(in_data_i.rest_len_c));

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q   <= u_d;
      v_q   <= v_d;
      w_q   <= w_d;
      rs_q  <= 34'(in_data_i.rest_len_a) + 34'(in_data_i.rest_len_b) +
               34'(in_data_i.rest_len_c);
      ta_q  <= sbc - 33'(in_data_i.rest_len_a);
      tb_q  <= sac - 33'(in_data_i.rest_len_b);
      tc_q  <= sab - 33'(in_data_i.rest_len_c);
      rok_q <= rok_d;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      evec[0][k] = w_q[k];
      evec[1][k] = v_q[k];
      evec[2][k] = u_q[k];
    end
  end

  // Cross product terms and squared edge components
  for (genvar k = 0; k < 3; k++) begin : g_cross
    localparam int unsigned I1 = (k + 1) % 3;
    localparam int unsigned I2 = (k + 2) % 3;

    assign sgn_d[k]     = u_q[I1][32] ^ v_q[I2][32];
    assign sgn_d[k + 3] = u_q[I2][32] ^ v_q[I1][32];

    tqm_mul #(.WA(33), .WB(33)) u_xa (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (mag33(u_q[I1])),
      .b_i   (mag33(v_q[I2])),
      .p_o   (xa_m[k])
    );

    tqm_mul #(.WA(33), .WB(33)) u_xb (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (mag33(u_q[I2])),
      .b_i   (mag33(v_q[I1])),
      .p_o   (xb_m[k])
    );
  end

  for (genvar i = 0; i < 3; i++) begin : g_edge
    for (genvar k = 0; k < 3; k++) begin : g_comp
      tqm_mul #(.WA(33), .WB(33)) u_esq (
        .clk_i (clk_i),
        .en_i  (en),
        .a_i   (mag33(evec[i][k])),
        .b_i   (mag33(evec[i][k])),
        .p_o   (esq_m[i][k])
      );
    end
  end

  tqm_delay #(.W(6), .N(LM)) u_sgn_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (sgn_d),
    .q_o   (sgn_m)
  );

  tqm_mul #(.WA(34), .WB(33)) u_p1 (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (rs_q),
    .b_i   (ta_q),
    .p_o   (p1_m)
  );

  tqm_mul #(.WA(33), .WB(33)) u_p2 (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (tb_q),
    .b_i   (tc_q),
    .p_o   (p2_m)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ca_s[k] = sgn_m[k]     ? -$signed({2'b00, xa_m[k]}) : $signed({2'b00, xa_m[k]});
      cb_s[k] = sgn_m[k + 3] ? -$signed({2'b00, xb_m[k]}) : $signed({2'b00, xb_m[k]});
      cr_s[k] = ca_s[k] - cb_s[k];
      cm_d[k] = cr_s[k][67] ? 67'(-cr_s[k]) : 67'(cr_s[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cm_q <= cm_d;
      for (int i = 0; i < 3; i++) begin
        es_q[i] <= esq_m[i][0] + esq_m[i][1] + esq_m[i][2];
      end
      p1_q <= p1_m;
      p2_q <= p2_m;
    end
  end

  // Squared cross product, rest product, degenerate and saturation tests
  for (genvar k = 0; k < 3; k++) begin : g_csq
    tqm_mul #(.WA(67), .WB(67)) u_csq (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (cm_q[k]),
      .b_i   (cm_q[k]),
      .p_o   (csq_m[k])
    );
  end

  tqm_mul #(.WA(67), .WB(66)) u_pp (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (p1_q),
    .b_i   (p2_q),
    .p_o   (pp_m)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      crsq_q <= 136'(csq_m[0]) + 136'(csq_m[1]) + 136'(csq_m[2]);
      pp_q   <= pp_m;
      deg_q  <= crsq_q <= 136'(f2);
      sat_q  <= 195'(crsq_q) >= (195'(pp_q) << 62);
    end
  end

  // Quality path
  for (genvar i = 0; i < 3; i++) begin : g_len
    tqm_sqrt #(.WX(98)) u_len (
      .clk_i  (clk_i),
      .en_i   (en),
      .rad_i  ({es_q[i], 32'b0}),
      .root_o (lroot[i])
    );
  end

  assign lsum = 51'(lroot[0]) + 51'(lroot[1]) + 51'(lroot[2]);

  tqm_delay #(.W(49), .N(T_LL - T_E)) u_lc_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (lroot[2]),
    .q_o   (lc_l)
  );

  tqm_delay #(.W(51), .N(T_L3 - T_E)) u_lsum_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (lsum),
    .q_o   (lsum_l)
  );

  tqm_mul #(.WA(49), .WB(49)) u_lalb (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (lroot[0]),
    .b_i   (lroot[1]),
    .p_o   (lalb_m)
  );

  tqm_mul #(.WA(98), .WB(49)) u_l3 (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (lalb_m),
    .b_i   (lc_l),
    .p_o   (l3_m)
  );

  tqm_mul #(.WA(147), .WB(51)) u_num (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (l3_m),
    .b_i   (lsum_l),
    .p_o   (num_m)
  );

  tqm_delay #(.W(136), .N(T_N - T_S)) u_crsq_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (crsq_q),
    .q_o   (crsq_n)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      ovf_q <= 169'(num_m[197:54]) >= (169'(crsq_n) << 33);
    end
  end

  tqm_div #(.WN(144), .WD(136), .WQ(33)) u_qdiv (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_m[197:54]),
    .den_i (crsq_n),
    .quo_o (quo)
  );

  tqm_delay #(.W(1), .N(T_QD - (T_N + 1))) u_ovf_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (ovf_q),
    .q_o   (ovf_l)
  );

  tqm_delay #(.W(1), .N(T_QD - T_F)) u_degq_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (deg_q),
    .q_o   (degq_l)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (degq_l || ovf_l || (quo > 33'(tqm_pkg::QUAL_CAP))) begin
        qual_q <= tqm_pkg::QUAL_CAP;
      end else begin
        qual_q <= quo[31:0];
      end
    end
  end

  tqm_delay #(.W(32), .N(T_R2 - T_QR)) u_qual_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (qual_q),
    .q_o   (qual_l)
  );

  // Stretch path
  tqm_div #(.WN(202), .WD(133), .WQ(128)) u_xdiv (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({crsq_q, 66'b0}),
    .den_i (pp_q),
    .quo_o (xq)
  );

  tqm_sqrt #(.WX(128)) u_root1 (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (xq),
    .root_o (r1)
  );

  tqm_sqrt #(.WX(64)) u_root2 (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (r1),
    .root_o (r2)
  );

  tqm_delay #(.W(1), .N(T_R2 - T_F)) u_deg_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (deg_q),
    .q_o   (deg_l)
  );

  tqm_delay #(.W(1), .N(T_R2 - T_F)) u_sat_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (sat_q),
    .q_o   (sat_l)
  );

  tqm_delay #(.W(1), .N(T_R2 - T_IN)) u_rok_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (rok_q),
    .q_o   (rok_l)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.quality    <= qual_l;
      out_q.degenerate <= deg_l;
      if (!rok_l) begin
        out_q.stretch <= '0;
      end else if (sat_l) begin
        out_q.stretch <= tqm_pkg::STRETCH_MAX;
      end else begin
        out_q.stretch <= r2;
      end
    end
  end

  `TQM_ASSERT(a_deg_cap, clk_i, rst_ni, out_valid_o && out_data_o.degenerate |-> out_data_o.quality == tqm_pkg::QUAL_CAP)
  `TQM_ASSERT(a_qual_max, clk_i, rst_ni, out_valid_o |-> out_data_o.quality <= tqm_pkg::QUAL_CAP)
  `TQM_ASSERT(a_stall_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> $stable(vld_q))
  `TQM_ASSERT_RST(a_rst_empty, clk_i, rst_ni, !out_valid_o)

endmodule
